@@ hdl/vts_pkg.sv @@
// ----------------------------------------------------------------------------
// vts_pkg: shared types and constants for the vertex transform/shade core
// Item layouts, register indexes, fixed-point constants, divider sizes.
// ----------------------------------------------------------------------------
package vts_pkg;

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_z;
    logic               last_vertex;
  } vtx_t;

  typedef struct packed {
    logic signed [31:0] clip_x;
    logic signed [31:0] clip_y;
    logic signed [31:0] clip_z;
    logic        [15:0] shaded_red;
    logic        [15:0] shaded_green;
    logic        [15:0] shaded_blue;
    logic               end_of_run;
  } res_t;

  typedef enum logic [2:0] {
    REG_SPIN_COS   = 3'd0,
    REG_SPIN_SIN   = 3'd1,
    REG_X_SCALE    = 3'd2,
    REG_BASE_RED   = 3'd3,
    REG_BASE_GREEN = 3'd4,
    REG_BASE_BLUE  = 3'd5
  } cfg_reg_e;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam int TILT_COS   = 14960;
  localparam int TILT_SIN_M = 6681;   // magnitude of the (negative) tilt sine
  localparam int PUSH_BACK  = 340787;
  localparam int W_MIN      = 5243;
  localparam int Y_SCALE    = 155007;
  localparam int LIGHT_X    = 5731;
  localparam int LIGHT_Y    = 12771;
  localparam int LIGHT_Z    = 8514;
  localparam int AMBIENT    = 6554;
  localparam int DIFFUSE    = 26214;
  localparam int COLOUR_MAX = 32768;

  // divider sizing: numerator magnitude, divisor, quotient bits
  // (19*w reaches 26 bits when the spin registers hold out-of-range values)
  localparam int DIV_NUM_W = 46;
  localparam int DIV_DEN_W = 26;
  localparam int DIV_QUO_W = 33;

endpackage

@@ hdl/vertex_transform_shade_core.sv @@
// Each accepted item runs through the stages and the valid pipeline to its result strobe (res_valid_o).
// Throughput: one item per cycle, every cycle; busy_o stays low.
// The 33-stage bit-per-stage divider computes x/w, y/w and z/w.
// The receiver cannot stall; results are strobed for exactly one cycle.
// Reset clears the valid pipeline and loads register defaults.
// ----------------------------------------------------------------------------
// vertex_transform_shade_core: vertex transform, projection and shading
// Spin, fixed tilt, push back, perspective divide with saturation, and
// ambient plus diffuse shading of the configured color.
// ----------------------------------------------------------------------------
module vertex_transform_shade_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  output logic                             busy_o,
  input  vts_pkg::vtx_t                    vtx_i,
  output logic                             res_valid_o,
  output vts_pkg::res_t                    res_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [vts_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [vts_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import vts_pkg::*;

  localparam int QW       = DIV_QUO_W;
  localparam int NW       = DIV_NUM_W;
  localparam int DW       = DIV_DEN_W;
  localparam int PIPE_LEN = 7 + QW;
  localparam int OUT_LAT  = PIPE_LEN + 1;
  localparam int COL_DLY  = QW - 5;
  localparam logic signed [47:0] Z_BIAS =
    48'sd8388608 - (48'(PUSH_BACK) <<< 24);

  typedef struct packed {
    logic neg_x;
    logic neg_y;
    logic neg_z;
    logic last;
  } side_t;

  typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
  } col_t;

  // configuration registers
  logic signed [15:0] spin_cos_q, spin_sin_q;
  logic        [23:0] scale_q;
  logic        [15:0] base_r_q, base_g_q, base_b_q;
  logic               accept;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spin_cos_q <= 16'sd16384;
      spin_sin_q <= 16'sd0;
      scale_q    <= 24'd155007;
      base_r_q   <= 16'd32768;
      base_g_q   <= 16'd32768;
      base_b_q   <= 16'd32768;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_SPIN_COS:   spin_cos_q <= cfg_data_i[15:0];
        REG_SPIN_SIN:   spin_sin_q <= cfg_data_i[15:0];
        REG_X_SCALE:    scale_q    <= cfg_data_i;
        REG_BASE_RED:   base_r_q   <= cfg_data_i[15:0];
        REG_BASE_GREEN: base_g_q   <= cfg_data_i[15:0];
        REG_BASE_BLUE:  base_b_q   <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // valid pipeline
  logic [PIPE_LEN-1:0] vld_q;
  logic                res_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      vld_q       <= {vld_q[PIPE_LEN-2:0], accept};
      res_valid_q <= vld_q[PIPE_LEN-1];
    end
  end

  // ---- stage 1: spin products
  logic signed [15:0] px, pz, nx, nz;
  logic signed [31:0] s1_pxc_q, s1_pzs_q, s1_pxs_q, s1_pzc_q;
  logic signed [31:0] s1_nxc_q, s1_nzs_q, s1_nxs_q, s1_nzc_q;
  logic signed [15:0] s1_py_q, s1_ny_q;
  logic               s1_last_q;

  assign px = vtx_i.pos_x;
  assign pz = vtx_i.pos_z;
  assign nx = vtx_i.norm_x;
  assign nz = vtx_i.norm_z;

  always_ff @(posedge clk_i) begin
    s1_pxc_q  <= px * spin_cos_q;
    s1_pzs_q  <= pz * spin_sin_q;
    s1_pxs_q  <= px * spin_sin_q;
    s1_pzc_q  <= pz * spin_cos_q;
    s1_nxc_q  <= nx * spin_cos_q;
    s1_nzs_q  <= nz * spin_sin_q;
    s1_nxs_q  <= nx * spin_sin_q;
    s1_nzc_q  <= nz * spin_cos_q;
    s1_py_q   <= vtx_i.pos_y;
    s1_ny_q   <= vtx_i.norm_y;
    s1_last_q <= vtx_i.last_vertex;
  end

  // ---- stage 2: spin sums
  logic signed [32:0] s2_x1_q, s2_z1_q, s2_m1_q, s2_mz1_q;
  logic signed [15:0] s2_py_q, s2_ny_q;
  logic               s2_last_q;

  always_ff @(posedge clk_i) begin
    s2_x1_q   <= 33'(s1_pxc_q) + 33'(s1_pzs_q);
    s2_z1_q   <= 33'(s1_pzc_q) - 33'(s1_pxs_q);
    s2_m1_q   <= 33'(s1_nxc_q) + 33'(s1_nzs_q);
    s2_mz1_q  <= 33'(s1_nzc_q) - 33'(s1_nxs_q);
    s2_py_q   <= s1_py_q;
    s2_ny_q   <= s1_ny_q;
    s2_last_q <= s1_last_q;
  end

  // ---- stage 3: tilt products, x rounded to Q.16
  logic signed [33:0] x1_rnd;
  logic signed [23:0] s3_xq_q;
  logic signed [31:0] s3_pa_q, s3_pc_q, s3_na_q, s3_nc_q;
  logic signed [46:0] s3_pb_q, s3_nb_q;
  logic signed [47:0] s3_pe_q, s3_ne_q;
  logic signed [32:0] s3_m1_q;
  logic               s3_last_q;

  assign x1_rnd = 34'(s2_x1_q) + 34'sd512;

  always_ff @(posedge clk_i) begin
    s3_xq_q   <= 24'(x1_rnd >>> 10);
    s3_pa_q   <= 32'(s2_py_q) * 32'(TILT_COS);
    s3_pc_q   <= 32'(s2_py_q) * 32'(TILT_SIN_M);
    s3_pb_q   <= 47'(s2_z1_q) * 47'(TILT_SIN_M);
    s3_pe_q   <= 48'(s2_z1_q) * 48'(TILT_COS);
    s3_na_q   <= 32'(s2_ny_q) * 32'(TILT_COS);
    s3_nc_q   <= 32'(s2_ny_q) * 32'(TILT_SIN_M);
    s3_nb_q   <= 47'(s2_mz1_q) * 47'(TILT_SIN_M);
    s3_ne_q   <= 48'(s2_mz1_q) * 48'(TILT_COS);
    s3_m1_q   <= s2_m1_q;
    s3_last_q <= s2_last_q;
  end

  // ---- stage 4: tilt sums and rounding; push back folded into z bias
  logic signed [47:0] yt, zt, m2t, mz2t;
  logic signed [23:0] s4_xq_q, s4_yq_q, s4_zq_q;
  logic signed [33:0] s4_m1_q, s4_m2_q, s4_mz2_q;
  logic               s4_last_q;

  assign yt   = (48'(s3_pa_q) <<< 14) + 48'(s3_pb_q) + 48'sd8388608;
  assign zt   = 48'(s3_pe_q) - (48'(s3_pc_q) <<< 14) + Z_BIAS;
  assign m2t  = (48'(s3_na_q) <<< 14) + 48'(s3_nb_q) + 48'sd8192;
  assign mz2t = s3_ne_q - (48'(s3_nc_q) <<< 14) + 48'sd8192;

  always_ff @(posedge clk_i) begin
    s4_xq_q   <= s3_xq_q;
    s4_yq_q   <= 24'(yt >>> 24);
    s4_zq_q   <= 24'(zt >>> 24);
    s4_m1_q   <= 34'(s3_m1_q);
    s4_m2_q   <= 34'(m2t >>> 14);
    s4_mz2_q  <= 34'(mz2t >>> 14);
    s4_last_q <= s3_last_q;
  end

  // ---- stage 5: w, numerators, light products
  logic signed [24:0] wz;
  logic        [21:0] w_d;
  logic        [21:0] s5_w_q;
  logic signed [47:0] s5_numx_q, s5_numy_q;
  logic signed [31:0] s5_nzb_q;
  logic signed [47:0] s5_dx_q, s5_dy_q, s5_dz_q;
  logic               s5_last_q;

  assign wz  = -25'(s4_zq_q);
  assign w_d = (wz < 25'(W_MIN)) ? 22'(W_MIN) : 22'(wz);

  always_ff @(posedge clk_i) begin
    s5_w_q    <= w_d;
    s5_numx_q <= $signed({1'b0, scale_q}) * s4_xq_q;
    s5_numy_q <= 48'(s4_yq_q) * 48'(Y_SCALE);
    s5_nzb_q  <= 32'(s4_zq_q) * -32'sd21 - 32'sd2621440;
    s5_dx_q   <= 48'(s4_m1_q) * 48'(LIGHT_X);
    s5_dy_q   <= 48'(s4_m2_q) * 48'(LIGHT_Y);
    s5_dz_q   <= 48'(s4_mz2_q) * 48'(LIGHT_Z);
    s5_last_q <= s4_last_q;
  end

  // ---- stage 6: sign and magnitude, z divisor, dot sum
  logic        [31:0] nzb_abs;
  logic        [NW-1:0] s6_xmag_q, s6_ymag_q, s6_zmag_q;
  logic               s6_negx_q, s6_negy_q, s6_negz_q;
  logic        [21:0] s6_w_q;
  logic        [DW-1:0] s6_denz_q;
  logic signed [49:0] s6_dot_q;
  logic               s6_last_q;

  assign nzb_abs = (s5_nzb_q < 0) ? 32'(-s5_nzb_q) : 32'(s5_nzb_q);

  always_ff @(posedge clk_i) begin
    s6_xmag_q <= (s5_numx_q < 0) ? NW'(-s5_numx_q) : NW'(s5_numx_q);
    s6_ymag_q <= (s5_numy_q < 0) ? NW'(-s5_numy_q) : NW'(s5_numy_q);
    s6_zmag_q <= NW'(nzb_abs) << 16;
    s6_negx_q <= s5_numx_q < 0;
    s6_negy_q <= s5_numy_q < 0;
    s6_negz_q <= s5_nzb_q < 0;
    s6_w_q    <= s5_w_q;
    s6_denz_q <= DW'(s5_w_q) * DW'(19);
    s6_dot_q  <= 50'(s5_dx_q) + 50'(s5_dy_q) + 50'(s5_dz_q);
    s6_last_q <= s5_last_q;
  end

  // ---- stage 7: add half divisor (round half away from zero), |n.l|
  logic [NW-1:0] s7_numx_q, s7_numy_q, s7_numz_q;
  logic [DW-1:0] s7_denxy_q, s7_denz_q;
  logic [48:0]   s7_adot_q;
  side_t         s7_side_q;

  always_ff @(posedge clk_i) begin
    s7_numx_q  <= s6_xmag_q + NW'(s6_w_q >> 1);
    s7_numy_q  <= s6_ymag_q + NW'(s6_w_q >> 1);
    s7_numz_q  <= s6_zmag_q + NW'(s6_denz_q >> 1);
    s7_denxy_q <= DW'(s6_w_q);
    s7_denz_q  <= s6_denz_q;
    s7_adot_q  <= (s6_dot_q < 0) ? 49'(-s6_dot_q) : 49'(s6_dot_q);
    s7_side_q  <= '{neg_x: s6_negx_q, neg_y: s6_negy_q, neg_z: s6_negz_q,
                    last: s6_last_q};
  end

  // ---- perspective divides
  logic [QW-1:0] quo_x, quo_y, quo_z;

  vts_div #(.NumW(NW), .DenW(DW), .QuoW(QW)) u_div_x (
    .clk_i (clk_i),
    .num_i (s7_numx_q),
    .den_i (s7_denxy_q),
    .quo_o (quo_x)
  );

  vts_div #(.NumW(NW), .DenW(DW), .QuoW(QW)) u_div_y (
    .clk_i (clk_i),
    .num_i (s7_numy_q),
    .den_i (s7_denxy_q),
    .quo_o (quo_y)
  );

  vts_div #(.NumW(NW), .DenW(DW), .QuoW(QW)) u_div_z (
    .clk_i (clk_i),
    .num_i (s7_numz_q),
    .den_i (s7_denz_q),
    .quo_o (quo_z)
  );

  side_t side_q [QW];

  always_ff @(posedge clk_i) begin
    side_q[0] <= s7_side_q;
    for (int i = 1; i < QW; i++) begin
      side_q[i] <= side_q[i-1];
    end
  end

  // ---- shading, stages 8..12
  logic [22:0] s8_d_q;
  logic [37:0] s9_pd_q;
  logic [23:0] s10_shade_q;
  logic [39:0] s11_r_q, s11_g_q, s11_b_q;
  col_t        col_d;
  col_t        s12_col_q;
  col_t        col_q [COL_DLY];

  function automatic logic [15:0] col_round(logic [39:0] prod);
    logic [39:0] t;
    t = (prod + 40'd16384) >> 15;
    return (t > 40'(COLOUR_MAX)) ? 16'(COLOUR_MAX) : 16'(t);
  endfunction

  assign col_d = '{red: col_round(s11_r_q), green: col_round(s11_g_q),
                   blue: col_round(s11_b_q)};

  always_ff @(posedge clk_i) begin
    s8_d_q      <= 23'((s7_adot_q + 49'd67108864) >> 27);
    s9_pd_q     <= 38'(s8_d_q) * 38'(DIFFUSE);
    s10_shade_q <= 24'(AMBIENT) + 24'((s9_pd_q + 38'd16384) >> 15);
    s11_r_q     <= 40'(base_r_q) * 40'(s10_shade_q);
    s11_g_q     <= 40'(base_g_q) * 40'(s10_shade_q);
    s11_b_q     <= 40'(base_b_q) * 40'(s10_shade_q);
    s12_col_q   <= col_d;
    col_q[0]    <= s12_col_q;
    for (int i = 1; i < COL_DLY; i++) begin
      col_q[i] <= col_q[i-1];
    end
  end

  // ---- output stage: sign and saturate to Q16.16
  function automatic logic [31:0] clip_sat(logic [QW-1:0] q, logic neg);
    logic [31:0] r;
    if (!neg) begin
      r = (q > QW'(32'h7fff_ffff)) ? 32'h7fff_ffff : 32'(q);
    end else begin
      r = (q > QW'(33'h1_0000_0000 >> 1)) ? 32'h8000_0000 : -32'(q);
    end
    return r;
  endfunction

  res_t  res_q;
  side_t side_out;
  col_t  col_out;

  assign side_out = side_q[QW-1];
  assign col_out  = col_q[COL_DLY-1];

  always_ff @(posedge clk_i) begin
    res_q.clip_x       <= clip_sat(quo_x, side_out.neg_x);
    res_q.clip_y       <= clip_sat(quo_y, side_out.neg_y);
    res_q.clip_z       <= clip_sat(quo_z, side_out.neg_z);
    res_q.shaded_red   <= col_out.red;
    res_q.shaded_green <= col_out.green;
    res_q.shaded_blue  <= col_out.blue;
    res_q.end_of_run   <= side_out.last;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

`ifndef SYNTHESIS
  a_lat_fwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##OUT_LAT res_valid_o)
    else $error("accepted item produced no result");

  a_lat_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(accept, OUT_LAT))
    else $error("result without accepted item");

  a_col_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (res_o.shaded_red <= 16'(COLOUR_MAX)) &&
                    (res_o.shaded_green <= 16'(COLOUR_MAX)) &&
                    (res_o.shaded_blue <= 16'(COLOUR_MAX)))
    else $error("color above saturation limit");
`endif

endmodule

@@ hdl/vts_div.sv @@
// ----------------------------------------------------------------------------
// vts_div: pipelined restoring divider
// One quotient bit per stage, unsigned; the numerator's bits above the
// quotient width must already be below the divisor.
// ----------------------------------------------------------------------------
module vts_div #(
  parameter int NumW = vts_pkg::DIV_NUM_W,
  parameter int DenW = vts_pkg::DIV_DEN_W,
  parameter int QuoW = vts_pkg::DIV_QUO_W
) (
  input  logic            clk_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic [QuoW-1:0] quo_o
);

  logic [DenW-1:0] rem_src  [QuoW];
  logic [DenW-1:0] den_src  [QuoW];
  logic [QuoW-1:0] bits_src [QuoW];
  logic [DenW:0]   trial    [QuoW];
  logic [QuoW-1:0] ge;
  logic [DenW-1:0] rem_d    [QuoW];
  logic [QuoW-1:0] bits_d   [QuoW];
  logic [DenW-1:0] rem_q    [QuoW];
  logic [DenW-1:0] den_q    [QuoW];
  logic [QuoW-1:0] bits_q   [QuoW];

  always_comb begin
    rem_src[0]  = DenW'(num_i[NumW-1:QuoW]);
    den_src[0]  = den_i;
    bits_src[0] = num_i[QuoW-1:0];
    for (int s = 1; s < QuoW; s++) begin
      rem_src[s]  = rem_q[s-1];
      den_src[s]  = den_q[s-1];
      bits_src[s] = bits_q[s-1];
    end
  end

  // numerator bits leave at the top of bits, quotient bits enter at the bottom
  always_comb begin
    for (int s = 0; s < QuoW; s++) begin
      trial[s]  = {rem_src[s], bits_src[s][QuoW-1]};
      ge[s]     = trial[s] >= {1'b0, den_src[s]};
      rem_d[s]  = ge[s] ? DenW'(trial[s] - {1'b0, den_src[s]}) : DenW'(trial[s]);
      bits_d[s] = {bits_src[s][QuoW-2:0], ge[s]};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int s = 0; s < QuoW; s++) begin
      rem_q[s]  <= rem_d[s];
      den_q[s]  <= den_src[s];
      bits_q[s] <= bits_d[s];
    end
  end

  assign quo_o = bits_q[QuoW-1];

endmodule
